/* rtl/core/lta_pkg.sv */
// Shared types and constants for the toroidal life automaton.
package lta_pkg;

  // Field widths fixed by the command and result formats.
  localparam int KIND_W     = 2;
  localparam int ROW_FW     = 5;
  localparam int COL_FW     = 5;
  localparam int ROW_BITS_W = 32;

  // Default grid size.
  localparam int DEF_GRID_WIDTH  = 32;
  localparam int DEF_GRID_HEIGHT = 24;

  // Command codes carried in the kind field.
  typedef enum logic [KIND_W-1:0] {
    OP_TOGGLE  = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  // Classified command handed from the front end to the execution engine.
  typedef struct packed {
    op_t               op;
    logic              row_ok;  // row lies inside the grid
    logic              fetch;   // command needs the addressed row read first
    logic              flip;    // toggle that really changes a cell
    logic [ROW_FW-1:0] row;
    logic [COL_FW-1:0] col;
  } cmd_t;

  // Execution engine states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SWEEP,
    BK_REREAD
  } bk_state_t;

endpackage

/* rtl/core/lta_front.sv */
// Front end: accepts command beats and classifies them for the engine.
module lta_front import lta_pkg::*; #(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic              push,
  output logic              full,
  input  logic [KIND_W-1:0] kind,
  input  logic [ROW_FW-1:0] row,
  input  logic [COL_FW-1:0] col,
  output logic              q_wr,
  output cmd_t              q_data,
  input  logic              q_full
);

  localparam int HCW = $clog2(GRID_HEIGHT + 1) + ROW_FW;
  localparam int WCW = $clog2(GRID_WIDTH + 1) + COL_FW;

  logic row_ok;
  logic col_ok;
  op_t  op;

  // A beat is taken whenever the command queue has room.
  assign full = q_full;
  assign q_wr = push && !q_full;

  // Range checks on the addressed cell.
  assign row_ok = HCW'(row) < HCW'(GRID_HEIGHT);
  assign col_ok = WCW'(col) < WCW'(GRID_WIDTH);
  assign op     = op_t'(kind);

  // Classify the command.
  always_comb begin
    q_data        = '0;
    q_data.op     = op;
    q_data.row_ok = row_ok;
    q_data.row    = row;
    q_data.col    = col;
    unique case (op)
      OP_TOGGLE: begin
        q_data.fetch = row_ok;
        q_data.flip  = row_ok && col_ok;
      end
      OP_READ: begin
        q_data.fetch = row_ok;
      end
      OP_CLEAR, OP_ADVANCE: begin
        q_data.fetch = 1'b0;
      end
      default: begin
        q_data.fetch = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/core/lta_cmd_fifo.sv */
// Two-entry queue of classified commands between front end and engine.
module lta_cmd_fifo import lta_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // The queue refuses beats while reset is held.
  assign full    = rst || (count == 2'd2);
  assign empty   = count == 2'd0;
  assign rd_data = slots[rd_ptr];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd) begin
        rd_ptr <= !rd_ptr;
      end
      if (wr && !rd) begin
        count <= count + 2'd1;
      end else if (rd && !wr) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

/* rtl/core/lta_back.sv */
// Execution engine: grid banks, generation sweep and result register.
module lta_back import lta_pkg::*; #(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  cmd_t                  q_data,
  output logic                  q_rd,
  output logic                  empty,
  input  logic                  pop,
  output logic [ROW_BITS_W-1:0] row_bits
);

  localparam int RW = $clog2(GRID_HEIGHT);
  localparam int KW = $clog2(GRID_HEIGHT + 3);

  bk_state_t state, state_next;
  cmd_t      cmd;
  logic      active;

  // Grid banks with a valid bit per row; an invalid row reads as dead.
  logic [GRID_WIDTH-1:0]  mem [2][GRID_HEIGHT];
  logic [GRID_HEIGHT-1:0] vld [2];

  logic [GRID_WIDTH-1:0] rd_data;
  logic                  rd_vbit;
  logic [GRID_WIDTH-1:0] cur_row;

  // Memory port controls.
  logic                  rd_en;
  logic                  rd_bank;
  logic [RW-1:0]         rd_row;
  logic                  wr_en;
  logic                  wr_bank;
  logic [RW-1:0]         wr_row;
  logic [GRID_WIDTH-1:0] wr_data;

  // Sweep bookkeeping.
  logic [KW-1:0]         sw_k;
  logic [KW-1:0]         dat_k;
  logic                  dat_vld;
  logic [GRID_WIDTH-1:0] w_up;
  logic [GRID_WIDTH-1:0] w_mid;
  logic [KW-1:0]         sw_km1;
  logic [KW-1:0]         dat_km2;
  logic                  sw_issue;
  logic                  sw_done;

  logic                  res_valid;
  logic [ROW_BITS_W-1:0] res_bits;
  logic [GRID_WIDTH-1:0] new_row;
  logic [GRID_WIDTH-1:0] flip_mask;
  logic                  take;

  function automatic logic [RW-1:0] row_idx(input logic [ROW_FW-1:0] r);
    logic [RW+ROW_FW-1:0] tmp;
    tmp = (RW + ROW_FW)'(r);
    return tmp[RW-1:0];
  endfunction

  function automatic logic [ROW_BITS_W-1:0] to_result(input logic [GRID_WIDTH-1:0] r);
    logic [GRID_WIDTH+ROW_BITS_W-1:0] tmp;
    tmp = (GRID_WIDTH + ROW_BITS_W)'(r);
    return tmp[ROW_BITS_W-1:0];
  endfunction

  // Next generation of the middle row under rule B3/S23, columns wrapping.
  function automatic logic [GRID_WIDTH-1:0] life_row(
    input logic [GRID_WIDTH-1:0] up,
    input logic [GRID_WIDTH-1:0] mid,
    input logic [GRID_WIDTH-1:0] dn
  );
    logic [GRID_WIDTH-1:0] res;
    logic [3:0]            n;
    int                    cl;
    int                    cr;
    res = '0;
    for (int c = 0; c < GRID_WIDTH; c++) begin
      cl = (c + GRID_WIDTH - 1) % GRID_WIDTH;
      cr = (c + 1) % GRID_WIDTH;
      n = 4'(up[cl]) + 4'(up[c]) + 4'(up[cr]) + 4'(mid[cl]) + 4'(mid[cr])
        + 4'(dn[cl]) + 4'(dn[c]) + 4'(dn[cr]);
      res[c] = (n == 4'd3) || (mid[c] && n == 4'd2);
    end
    return res;
  endfunction

  assign cur_row   = rd_vbit ? rd_data : '0;
  assign flip_mask = {{(GRID_WIDTH-1){1'b0}}, 1'b1} << cmd.col;
  assign new_row   = cmd.flip ? (cur_row ^ flip_mask) : cur_row;
  assign take      = (state == BK_IDLE) && !res_valid && !q_empty;
  assign q_rd      = take;
  assign empty     = !res_valid;
  assign row_bits  = res_bits;

  // Sweep read order: last row, rows 0 to the last, then row 0 again.
  assign sw_km1   = sw_k - KW'(1);
  assign dat_km2  = dat_k - KW'(2);
  assign sw_issue = sw_k <= KW'(GRID_HEIGHT + 1);
  assign sw_done  = dat_vld && (dat_k == KW'(GRID_HEIGHT + 1));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (take) begin
          if (q_data.op == OP_ADVANCE) begin
            state_next = BK_SWEEP;
          end else if (q_data.fetch) begin
            state_next = BK_FETCH;
          end
        end
      end
      BK_FETCH: begin
        state_next = BK_IDLE;
      end
      BK_SWEEP: begin
        if (sw_done) begin
          state_next = BK_REREAD;
        end
      end
      BK_REREAD: begin
        state_next = cmd.row_ok ? BK_FETCH : BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Memory port controls per state.
  always_comb begin
    rd_en   = 1'b0;
    rd_bank = active;
    rd_row  = '0;
    wr_en   = 1'b0;
    wr_bank = active;
    wr_row  = '0;
    wr_data = new_row;
    unique case (state)
      BK_IDLE: begin
        if (take && q_data.fetch) begin
          rd_en  = 1'b1;
          rd_row = row_idx(q_data.row);
        end
      end
      BK_FETCH: begin
        if (cmd.flip) begin
          wr_en  = 1'b1;
          wr_row = row_idx(cmd.row);
        end
      end
      BK_SWEEP: begin
        rd_en = sw_issue;
        if (sw_k == '0) begin
          rd_row = RW'(GRID_HEIGHT - 1);
        end else if (sw_k == KW'(GRID_HEIGHT + 1)) begin
          rd_row = '0;
        end else begin
          rd_row = sw_km1[RW-1:0];
        end
        wr_en   = dat_vld && (dat_k >= KW'(2));
        wr_bank = !active;
        wr_row  = dat_km2[RW-1:0];
        wr_data = life_row(w_up, w_mid, cur_row);
      end
      BK_REREAD: begin
        rd_en  = cmd.row_ok;
        rd_row = row_idx(cmd.row);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Grid storage and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_bank][wr_row] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_bank][rd_row];
      rd_vbit <= vld[rd_bank][rd_row];
    end
  end

  // Control state, valid bits and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      active    <= 1'b0;
      vld[0]    <= '0;
      vld[1]    <= '0;
      res_valid <= 1'b0;
      dat_vld   <= 1'b0;
      sw_k      <= '0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        vld[wr_bank][wr_row] <= 1'b1;
      end
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      dat_vld <= (state == BK_SWEEP) && sw_issue;
      unique case (state)
        BK_IDLE: begin
          if (take) begin
            sw_k <= '0;
            if (q_data.op == OP_CLEAR) begin
              vld[active] <= '0;
            end
            if (q_data.op != OP_ADVANCE && !q_data.fetch) begin
              res_valid <= 1'b1;
            end
          end
        end
        BK_FETCH: begin
          res_valid <= 1'b1;
        end
        BK_SWEEP: begin
          if (sw_issue) begin
            sw_k <= sw_k + KW'(1);
          end
          if (sw_done) begin
            active <= !active;
          end
        end
        BK_REREAD: begin
          if (!cmd.row_ok) begin
            res_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= q_data;
    end
    if (state == BK_IDLE && take && !q_data.fetch && q_data.op != OP_ADVANCE) begin
      res_bits <= '0;
    end else if (state == BK_FETCH) begin
      res_bits <= to_result(new_row);
    end else if (state == BK_REREAD && !cmd.row_ok) begin
      res_bits <= '0;
    end
    if (state == BK_SWEEP) begin
      dat_k <= sw_k;
      if (dat_vld) begin
        w_up  <= w_mid;
        w_mid <= cur_row;
      end
    end
  end

endmodule

/* rtl/core/life_automaton_torus_grid.sv */
// Top level of the toroidal B3/S23 life automaton with command queue interface.
//
//   channel   handshake        payload
//   command   push / full      kind, row, col
//   result    pop / empty      row_bits
//
// A clear, or a toggle or read of a row outside the grid, shows its result
// straight from the idle state; a toggle or read inside the grid first reads its
// row. An advance sweeps the grid, reading one source row per cycle through one
// port, then rereads the addressed row unless it lies outside the grid.
// The engine waits while its result is not popped; the queue holds two more beats.
// Reset is synchronous, holds full high and leaves every cell dead.
module life_automaton_torus_grid import lta_pkg::*; #(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [KIND_W-1:0]     kind,
  input  logic [ROW_FW-1:0]     row,
  input  logic [COL_FW-1:0]     col,
  output logic                  empty,
  input  logic                  pop,
  output logic [ROW_BITS_W-1:0] row_bits
);

  logic q_wr;
  logic q_full;
  logic q_rd;
  logic q_empty;
  cmd_t q_wr_data;
  cmd_t q_rd_data;

  // Command intake and classification.
  lta_front #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_front (
    .push  (push),
    .full  (full),
    .kind  (kind),
    .row   (row),
    .col   (col),
    .q_wr  (q_wr),
    .q_data(q_wr_data),
    .q_full(q_full)
  );

  // Queue between the front end and the engine.
  lta_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_data(q_wr_data),
    .full   (q_full),
    .rd     (q_rd),
    .rd_data(q_rd_data),
    .empty  (q_empty)
  );

  // Grid engine and result register.
  lta_back #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .row_bits(row_bits)
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the toroidal B3/S23 life automaton with queue-style ports.
module tb_top;
  import lta_pkg::*;

  localparam int GRID_W         = DEF_GRID_WIDTH;
  localparam int GRID_H         = DEF_GRID_HEIGHT;
  localparam int RANDOM_BEATS   = 900;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int NUM_DIRECTED   = 25;

  // One directed command; fixed marks rows whose result is typed in by hand.
  typedef struct packed {
    op_t                   op;
    logic [ROW_FW-1:0]     row;
    logic [COL_FW-1:0]     col;
    logic                  fixed;
    logic [ROW_BITS_W-1:0] bits;
  } probe_t;

  logic                  clk   = 1'b0;
  logic                  rst   = 1'b1;
  logic                  push  = 1'b0;
  logic                  full;
  op_t                   kind  = OP_READ;
  logic [ROW_FW-1:0]     row   = '0;
  logic [COL_FW-1:0]     col   = '0;
  logic                  empty;
  logic                  pop   = 1'b0;
  logic [ROW_BITS_W-1:0] row_bits;

  // Predicted grid as shown to the user; the bank swap is invisible from outside.
  logic [GRID_W-1:0]     life_cells [GRID_H];
  logic [ROW_BITS_W-1:0] expected_rows [$];

  int error_count    = 0;
  int cycle_count    = 0;
  int beats_accepted = 0;
  int burst_left     = 0;

  // Directed commands: corners, wrap-around, out-of-range rows, clear, blinker, glider.
  probe_t directed_probes [NUM_DIRECTED] = '{
    '{OP_READ,    5'd0,  5'd0,  1'b1, 32'h0000_0000},
    '{OP_READ,    5'd31, 5'd31, 1'b1, 32'h0000_0000},
    '{OP_TOGGLE,  5'd0,  5'd0,  1'b1, 32'h0000_0001},
    '{OP_TOGGLE,  5'd0,  5'd31, 1'b1, 32'h8000_0001},
    '{OP_TOGGLE,  5'd23, 5'd31, 1'b1, 32'h8000_0000},
    '{OP_TOGGLE,  5'd23, 5'd0,  1'b1, 32'h8000_0001},
    '{OP_TOGGLE,  5'd24, 5'd5,  1'b1, 32'h0000_0000},
    '{OP_TOGGLE,  5'd31, 5'd31, 1'b1, 32'h0000_0000},
    '{OP_ADVANCE, 5'd0,  5'd9,  1'b0, 32'h0000_0000},
    '{OP_ADVANCE, 5'd31, 5'd0,  1'b1, 32'h0000_0000},
    '{OP_READ,    5'd23, 5'd0,  1'b0, 32'h0000_0000},
    '{OP_CLEAR,   5'd0,  5'd17, 1'b1, 32'h0000_0000},
    '{OP_READ,    5'd23, 5'd0,  1'b1, 32'h0000_0000},
    '{OP_TOGGLE,  5'd12, 5'd4,  1'b0, 32'h0000_0000},
    '{OP_TOGGLE,  5'd12, 5'd5,  1'b0, 32'h0000_0000},
    '{OP_TOGGLE,  5'd12, 5'd6,  1'b0, 32'h0000_0000},
    '{OP_ADVANCE, 5'd11, 5'd0,  1'b0, 32'h0000_0000},
    '{OP_ADVANCE, 5'd12, 5'd0,  1'b0, 32'h0000_0000},
    '{OP_CLEAR,   5'd12, 5'd0,  1'b1, 32'h0000_0000},
    '{OP_TOGGLE,  5'd22, 5'd30, 1'b0, 32'h0000_0000},
    '{OP_TOGGLE,  5'd23, 5'd31, 1'b0, 32'h0000_0000},
    '{OP_TOGGLE,  5'd0,  5'd29, 1'b0, 32'h0000_0000},
    '{OP_TOGGLE,  5'd0,  5'd30, 1'b0, 32'h0000_0000},
    '{OP_TOGGLE,  5'd0,  5'd31, 1'b0, 32'h0000_0000},
    '{OP_ADVANCE, 5'd0,  5'd0,  1'b0, 32'h0000_0000}
  };

  life_automaton_torus_grid dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .kind     (kind),
    .row      (row),
    .col      (col),
    .empty    (empty),
    .pop      (pop),
    .row_bits (row_bits)
  );

  always #4 clk = ~clk;

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [ROW_BITS_W-1:0] want,
                                 input logic [ROW_BITS_W-1:0] got);
    $display("[%0t] mismatch: %s: expected row_bits %h, got %h", $time, what, want, got);
    error_count++;
  endtask

  // Apply one command to the predicted grid and return the row the block should show.
  task automatic step_life_model(input op_t op, input logic [ROW_FW-1:0] r,
                                 input logic [COL_FW-1:0] c,
                                 output logic [ROW_BITS_W-1:0] bits);
    logic [GRID_W-1:0] next_cells [GRID_H];
    int y, x, dy, dx, n;
    case (op)
      OP_TOGGLE: begin
        if (r < GRID_H && c < GRID_W) life_cells[r][c] = ~life_cells[r][c];
      end
      OP_CLEAR: begin
        for (y = 0; y < GRID_H; y++) life_cells[y] = '0;
      end
      OP_ADVANCE: begin
        // Count the eight neighbors with wrap-around on both axes.
        for (y = 0; y < GRID_H; y++) begin
          for (x = 0; x < GRID_W; x++) begin
            n = 0;
            for (dy = 0; dy < 3; dy++) begin
              for (dx = 0; dx < 3; dx++) begin
                if (!(dy == 1 && dx == 1))
                  n += life_cells[(y + GRID_H - 1 + dy) % GRID_H][(x + GRID_W - 1 + dx) % GRID_W];
              end
            end
            next_cells[y][x] = (n == 3) || (n == 2 && life_cells[y][x]);
          end
        end
        life_cells = next_cells;
      end
      default: begin
      end
    endcase
    bits = (r < GRID_H) ? ROW_BITS_W'(life_cells[r]) : '0;
  endtask

  // Offer one command beat, idling between bursts, and record the expected row once taken.
  task automatic send_command(input op_t op, input logic [ROW_FW-1:0] r,
                              input logic [COL_FW-1:0] c, input logic fixed,
                              input logic [ROW_BITS_W-1:0] fixed_bits);
    logic [ROW_BITS_W-1:0] model_bits;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = ($urandom_range(7) == 0) ? 150 : $urandom_range(24, 1);
    end
    push <= 1'b1;
    kind <= op;
    row  <= r;
    col  <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    step_life_model(op, r, c, model_bits);
    expected_rows.push_back(fixed ? fixed_bits : model_bits);
    burst_left--;
    beats_accepted++;
  endtask

  // Stimulus: reset, directed table, then phases of seeding and evolving.
  initial begin
    op_t               rand_op;
    logic [ROW_FW-1:0] rand_row;
    logic [COL_FW-1:0] rand_col;
    int                pick, seeding;
    for (int y = 0; y < GRID_H; y++) life_cells[y] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_probes[i])
      send_command(directed_probes[i].op, directed_probes[i].row, directed_probes[i].col,
                   directed_probes[i].fixed, directed_probes[i].bits);

    // Seeding phases mostly toggle cells; evolving phases mostly advance and read.
    seeding = 1;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 30 == 0) seeding = ($urandom_range(1) == 0);
      pick = $urandom_range(99);
      if (seeding)
        rand_op = (pick < 70) ? OP_TOGGLE : (pick < 85) ? OP_READ :
                  (pick < 98) ? OP_ADVANCE : OP_CLEAR;
      else
        rand_op = (pick < 20) ? OP_TOGGLE : (pick < 50) ? OP_READ :
                  (pick < 98) ? OP_ADVANCE : OP_CLEAR;
      rand_row = ($urandom_range(9) == 0) ? ROW_FW'($urandom_range(31, GRID_H))
                                          : ROW_FW'($urandom_range(GRID_H - 1, 0));
      rand_col = COL_FW'($urandom_range(31, 0));
      send_command(rand_op, rand_row, rand_col, 1'b0, '0);
    end
    push <= 1'b0;

    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("life_automaton_torus_grid regression: pass");
    end else begin
      $display("life_automaton_torus_grid regression: fail");
    end
    $finish;
  end

  // Result side: check each popped beat, then pick pop from a stall pattern.
  logic [7:0] stall_pattern = 8'hFF;
  int         pattern_pos   = 0;
  int         hold_left     = 0;
  int         holds_done    = 0;

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_rows.size() == 0)
        report_mismatch("result beat with nothing expected", '0, row_bits);
      else if (row_bits !== expected_rows[0])
        report_mismatch("row_bits", expected_rows.pop_front(), row_bits);
      else
        void'(expected_rows.pop_front());
    end

    // Two long hold-offs let the command side fill up and stall.
    if (hold_left == 0 && holds_done < 2 && beats_accepted >= 150 + 450 * holds_done) begin
      hold_left = 500;
      holds_done++;
    end

    if (pattern_pos % 64 == 0)
      stall_pattern = ($urandom_range(2) == 0) ? 8'hFF : 8'($urandom);
    pattern_pos++;

    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= stall_pattern[pattern_pos % 8];
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("life_automaton_torus_grid regression: fail");
      $finish;
    end
  end

endmodule

/* sim.f */
rtl/core/lta_pkg.sv
rtl/core/lta_front.sv
rtl/core/lta_cmd_fifo.sv
rtl/core/lta_back.sv
rtl/core/life_automaton_torus_grid.sv
sim/tb_top.sv
